@@ src/salru_pkg.sv @@
// Shared constants and types for the set-associative LRU tag store.
// Holds the geometry defaults, the stream widths and the control state type.
// No dependencies.
package salru_pkg;

  localparam int unsigned LINE_SIZE    = 64;
  localparam int unsigned SET_COUNT    = 8;
  localparam int unsigned WAY_COUNT    = 4;
  localparam int unsigned ADDRESS_BITS = 32;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 8;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

endpackage

@@ src/set_assoc_lru_cache_tag_model_core.sv @@
// Tag store of a set-associative cache with least-recently-used replacement.
// Depends on salru_pkg for the geometry defaults, stream widths and state type.
// Usage:
//   The slave stream carries one byte address per beat; the master stream
//   returns one beat per access whose bit 0 is set on a hit and cleared on a
//   miss, in which case the line has been filled into the set.
//   Each set is one row of a synchronous memory holding the valid bits, tags
//   and recency ranks of all its ways. An accepted beat reads its row; the
//   lookup state then compares every way in parallel, updates the ranks and
//   writes the row back while loading the result register.
//   The block takes no new address until the read and write-back of the set
//   row through the single memory port pair are done.
//   After reset the block sweeps the memory one row per cycle, clearing the
//   valid bits and ranking the ways by index; tready stays low during that
//   sweep.
//   A result waits in its register while the receiver stalls; one further
//   address is still taken and its lookup waits until the result is taken.
//   LINE_SIZE and SET_COUNT must be powers of two.
module set_assoc_lru_cache_tag_model_core #(
  parameter int unsigned LINE_SIZE    = salru_pkg::LINE_SIZE,
  parameter int unsigned SET_COUNT    = salru_pkg::SET_COUNT,
  parameter int unsigned WAY_COUNT    = salru_pkg::WAY_COUNT,
  parameter int unsigned ADDRESS_BITS = salru_pkg::ADDRESS_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [salru_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,  // [31:0] byte_address
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [salru_pkg::OUT_DATA_W-1:0] m_axis_tdata_o   // [0] hit, [7:1] zero
);

  localparam int unsigned AB_EFF   = (ADDRESS_BITS < salru_pkg::IN_DATA_W) ?
                                     ADDRESS_BITS : salru_pkg::IN_DATA_W;
  localparam int unsigned OFF_W    = $clog2(LINE_SIZE);
  localparam int unsigned SET_BITS = $clog2(SET_COUNT);
  localparam int unsigned SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int unsigned TAG_RAW  = AB_EFF - OFF_W - SET_BITS;
  localparam int unsigned TAG_W    = (AB_EFF > OFF_W + SET_BITS) ? TAG_RAW : 1;
  localparam int unsigned RANK_W   = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam logic [RANK_W-1:0] RANK_LRU = RANK_W'(WAY_COUNT - 1);
  localparam logic [SET_W-1:0]  SET_LAST = SET_W'(SET_COUNT - 1);

  typedef struct packed {
    logic [WAY_COUNT-1:0]             valid;
    logic [WAY_COUNT-1:0][TAG_W-1:0]  tag;
    logic [WAY_COUNT-1:0][RANK_W-1:0] rank;
  } row_t;

  salru_pkg::state_e state_q, state_d;

  row_t              mem_q [SET_COUNT];
  row_t              rd_row_q;
  row_t              wr_row;
  row_t              upd_row;
  row_t              clr_row;
  logic [SET_W-1:0]  clr_q, clr_d;
  logic [SET_W-1:0]  set_q;
  logic [TAG_W-1:0]  tag_q;
  logic [SET_W-1:0]  in_set;
  logic [TAG_W-1:0]  in_tag;
  logic [SET_W-1:0]  wr_addr;
  logic              wr_en;
  logic              rd_en;
  logic              out_load;
  logic              out_valid_q, out_valid_d;
  logic              hit_q;

  logic [WAY_COUNT-1:0] hit_vec;
  logic                 hit;
  logic [RANK_W-1:0]    hit_way;
  logic                 inv_found;
  logic [RANK_W-1:0]    inv_way;
  logic [RANK_W-1:0]    lru_way;
  logic [RANK_W-1:0]    target;
  logic [RANK_W-1:0]    old_rank;

  assign in_set = (SET_BITS > 0) ? s_axis_tdata_i[OFF_W +: SET_W] : '0;
  assign in_tag = (AB_EFF > OFF_W + SET_BITS) ?
                  s_axis_tdata_i[OFF_W + SET_BITS +: TAG_W] : '0;

  always_comb begin
    hit_vec   = '0;
    hit_way   = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    lru_way   = '0;
    for (int unsigned w = 0; w < WAY_COUNT; w++) begin
      hit_vec[w] = rd_row_q.valid[w] && (rd_row_q.tag[w] == tag_q);
      if (hit_vec[w]) begin
        hit_way = RANK_W'(w);
      end
      if (!rd_row_q.valid[w] && !inv_found) begin
        inv_found = 1'b1;
        inv_way   = RANK_W'(w);
      end
      if (rd_row_q.rank[w] == RANK_LRU) begin
        lru_way = RANK_W'(w);
      end
    end
    hit = |hit_vec;
    if (hit) begin
      target = hit_way;
    end else if (inv_found) begin
      target = inv_way;
    end else begin
      target = lru_way;
    end
    old_rank = rd_row_q.rank[target];
    upd_row  = rd_row_q;
    for (int unsigned w = 0; w < WAY_COUNT; w++) begin
      if (RANK_W'(w) == target) begin
        upd_row.valid[w] = 1'b1;
        upd_row.tag[w]   = tag_q;
        upd_row.rank[w]  = '0;
      end else if (rd_row_q.rank[w] < old_rank) begin
        upd_row.rank[w] = rd_row_q.rank[w] + RANK_W'(1);
      end
    end
  end

  always_comb begin
    clr_row       = '0;
    for (int unsigned w = 0; w < WAY_COUNT; w++) begin
      clr_row.rank[w] = RANK_W'(w);
    end
  end

  always_comb begin
    state_d         = state_q;
    clr_d           = clr_q;
    out_valid_d     = out_valid_q;
    s_axis_tready_o = 1'b0;
    rd_en           = 1'b0;
    wr_en           = 1'b0;
    out_load        = 1'b0;
    wr_addr         = set_q;
    wr_row          = upd_row;
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      salru_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_row  = clr_row;
        if (clr_q == SET_LAST) begin
          state_d = salru_pkg::ST_IDLE;
        end else begin
          clr_d = clr_q + SET_W'(1);
        end
      end
      salru_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          rd_en   = 1'b1;
          state_d = salru_pkg::ST_LOOKUP;
        end
      end
      salru_pkg::ST_LOOKUP: begin
        if (!out_valid_q || m_axis_tready_i) begin
          wr_en       = 1'b1;
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = salru_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = salru_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= salru_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      set_q    <= in_set;
      tag_q    <= in_tag;
      rd_row_q <= mem_q[in_set];
    end
    if (wr_en) begin
      mem_q[wr_addr] <= wr_row;
    end
    if (out_load) begin
      hit_q <= hit;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(salru_pkg::OUT_DATA_W - 1){1'b0}}, hit_q};

endmodule
